FILE: hw/rtl/odpw_pkg.sv
// ---------------------------------------------------------------------------
// odpw_pkg: shared types, constants and helpers for the dither pixel writer
// Holds the register map, the 16x16 threshold matrix and the small
// arithmetic helpers used by the pipeline stages.
// ---------------------------------------------------------------------------
package odpw_pkg;

  // Channel and coordinate widths
  localparam int CHANNEL_BITS  = 8;
  localparam int COORD_BITS    = 12;
  localparam int OUT_XY_BITS   = 11;
  localparam int LEVEL_BITS    = 5;
  localparam int GAIN_BITS     = 13;
  localparam int INDEX_BITS    = 16;
  localparam int MAX_WIDTH_DEF = 2048;

  // Register reset values
  localparam logic [11:0] WIDTH_RST  = 12'd1280;
  localparam logic [11:0] HEIGHT_RST = 12'd1024;
  localparam logic [4:0]  RED_RST    = 5'd8;
  localparam logic [4:0]  GREEN_RST  = 5'd8;
  localparam logic [4:0]  BLUE_RST   = 5'd4;

  // Alpha byte placed on top of a direct color word
  localparam logic [7:0] ALPHA_BYTE = 8'hFF;

  // Register map, word index (byte address / 4)
  typedef enum logic [2:0] {
    REG_COLOR_MODE   = 3'd0,
    REG_FRAME_WIDTH  = 3'd1,
    REG_FRAME_HEIGHT = 3'd2,
    REG_RED_LEVELS   = 3'd3,
    REG_GREEN_LEVELS = 3'd4,
    REG_BLUE_LEVELS  = 3'd5
  } reg_idx_t;

  // Side data that rides along with each pixel through the pipeline
  typedef struct packed {
    logic [OUT_XY_BITS-1:0]  x;
    logic [OUT_XY_BITS-1:0]  y;
    logic                    span_end;
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } pix_side_t;

  // Threshold matrix, row = x[3:0], column = y[3:0]
  localparam logic [7:0] THRESHOLDS [256] = '{
    8'd0,   8'd192, 8'd48,  8'd240, 8'd12,  8'd204, 8'd60,  8'd252,
    8'd3,   8'd195, 8'd51,  8'd243, 8'd15,  8'd207, 8'd63,  8'd255,
    8'd128, 8'd64,  8'd176, 8'd112, 8'd140, 8'd76,  8'd188, 8'd124,
    8'd131, 8'd67,  8'd179, 8'd115, 8'd143, 8'd79,  8'd191, 8'd127,
    8'd32,  8'd224, 8'd16,  8'd208, 8'd44,  8'd236, 8'd28,  8'd220,
    8'd35,  8'd227, 8'd19,  8'd211, 8'd47,  8'd239, 8'd31,  8'd223,
    8'd160, 8'd96,  8'd144, 8'd80,  8'd172, 8'd108, 8'd156, 8'd92,
    8'd163, 8'd99,  8'd147, 8'd83,  8'd175, 8'd111, 8'd159, 8'd95,
    8'd8,   8'd200, 8'd56,  8'd248, 8'd4,   8'd196, 8'd52,  8'd244,
    8'd11,  8'd203, 8'd59,  8'd251, 8'd7,   8'd199, 8'd55,  8'd247,
    8'd136, 8'd72,  8'd184, 8'd120, 8'd132, 8'd68,  8'd180, 8'd116,
    8'd139, 8'd75,  8'd187, 8'd123, 8'd135, 8'd71,  8'd183, 8'd119,
    8'd40,  8'd232, 8'd24,  8'd216, 8'd36,  8'd228, 8'd20,  8'd212,
    8'd43,  8'd235, 8'd27,  8'd219, 8'd39,  8'd231, 8'd23,  8'd215,
    8'd168, 8'd104, 8'd152, 8'd88,  8'd164, 8'd100, 8'd148, 8'd84,
    8'd171, 8'd107, 8'd155, 8'd91,  8'd167, 8'd103, 8'd151, 8'd87,
    8'd2,   8'd194, 8'd50,  8'd242, 8'd14,  8'd206, 8'd62,  8'd254,
    8'd1,   8'd193, 8'd49,  8'd241, 8'd13,  8'd205, 8'd61,  8'd253,
    8'd130, 8'd66,  8'd178, 8'd114, 8'd142, 8'd78,  8'd190, 8'd126,
    8'd129, 8'd65,  8'd177, 8'd113, 8'd141, 8'd77,  8'd189, 8'd125,
    8'd34,  8'd226, 8'd18,  8'd210, 8'd46,  8'd238, 8'd30,  8'd222,
    8'd33,  8'd225, 8'd17,  8'd209, 8'd45,  8'd237, 8'd29,  8'd221,
    8'd162, 8'd98,  8'd146, 8'd82,  8'd174, 8'd110, 8'd158, 8'd94,
    8'd161, 8'd97,  8'd145, 8'd81,  8'd173, 8'd109, 8'd157, 8'd93,
    8'd10,  8'd202, 8'd58,  8'd250, 8'd6,   8'd198, 8'd54,  8'd246,
    8'd9,   8'd201, 8'd57,  8'd249, 8'd5,   8'd197, 8'd53,  8'd245,
    8'd138, 8'd74,  8'd186, 8'd122, 8'd134, 8'd70,  8'd182, 8'd118,
    8'd137, 8'd73,  8'd185, 8'd121, 8'd133, 8'd69,  8'd181, 8'd117,
    8'd42,  8'd234, 8'd26,  8'd218, 8'd38,  8'd230, 8'd22,  8'd214,
    8'd41,  8'd233, 8'd25,  8'd217, 8'd37,  8'd229, 8'd21,  8'd213,
    8'd170, 8'd106, 8'd154, 8'd90,  8'd166, 8'd102, 8'd150, 8'd86,
    8'd169, 8'd105, 8'd153, 8'd89,  8'd165, 8'd101, 8'd149, 8'd85
  };

  // A level count of zero acts as one level
  function automatic logic [LEVEL_BITS-1:0] eff_levels(input logic [LEVEL_BITS-1:0] n);
    return (n == '0) ? LEVEL_BITS'(1) : n;
  endfunction

  // Scale factor (levels-1)*256 + 1
  function automatic logic [GAIN_BITS-1:0] chan_gain(input logic [LEVEL_BITS-1:0] n);
    logic [LEVEL_BITS-1:0] m;
    m = eff_levels(n) - LEVEL_BITS'(1);
    return {m, 8'h01};
  endfunction

  // Integer level plus one when the fraction beats the threshold
  function automatic logic [LEVEL_BITS-1:0] dither_level(
    input logic [GAIN_BITS-1:0] e,
    input logic [7:0]           thr
  );
    return e[GAIN_BITS-1:8] + ((e[7:0] > thr) ? LEVEL_BITS'(1) : LEVEL_BITS'(0));
  endfunction

endpackage

FILE: hw/rtl/ordered_dither_pixel_writer_unit.sv
// ---------------------------------------------------------------------------
// ordered_dither_pixel_writer_unit: clipped, ordered-dither pixel writer
// Takes one pixel beat per clock, drops pixels outside the frame, and
// writes a dithered color index or a packed direct color word.
// ---------------------------------------------------------------------------
// Usage:
//   A pixel beat (pixel_x, pixel_y, red_in, green_in, blue_in, span_end) is
//   taken at each rising edge with start high; busy stays low, so a new
//   pixel may be presented every cycle.
//   A visible pixel appears on out_x, out_y, pixel_word and out_span_end
//   for one cycle with done high, once it has passed the register stages.
//   Pixels off the frame give no beat. Results leave in input order.
//   Throughput is one pixel per clock; the six register stages (input,
//   clip/threshold, channel multiply, level, index multiply, output) each
//   hold one pixel.
//   The receiver cannot hold results off; none is needed as nothing ever backs up.
//   Registers sit on the APB port at byte address 4*i; the user must write
//   them only while no pixel is in flight, which the block does not enforce.
//   Reset clears the pipeline valid bits and loads the register defaults
//   (indexed mode, 1280x1024, 8/8/4 levels).
// ---------------------------------------------------------------------------
module ordered_dither_pixel_writer_unit #(
  parameter int MAX_WIDTH = odpw_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,

  // pixel command
  input  logic        start,
  output logic        busy,
  input  logic [11:0] pixel_x,
  input  logic [11:0] pixel_y,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic        span_end,

  // result strobe
  output logic        done,
  output logic [10:0] out_x,
  output logic [10:0] out_y,
  output logic [31:0] pixel_word,
  output logic        out_span_end,

  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [12:0] MaxW = 13'(MAX_WIDTH);
  localparam int LB = odpw_pkg::LEVEL_BITS;
  localparam int GB = odpw_pkg::GAIN_BITS;
  localparam int CB = odpw_pkg::CHANNEL_BITS;
  localparam int PB = CB + GB;

  // configuration registers
  logic          color_mode;
  logic [11:0]   frame_width;
  logic [11:0]   frame_height;
  logic [LB-1:0] red_levels;
  logic [LB-1:0] green_levels;
  logic [LB-1:0] blue_levels;

  odpw_pkg::reg_idx_t reg_sel;
  logic               cfg_wr;

  assign reg_sel = odpw_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign busy    = 1'b0;

  // write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode   <= 1'b0;
      frame_width  <= odpw_pkg::WIDTH_RST;
      frame_height <= odpw_pkg::HEIGHT_RST;
      red_levels   <= odpw_pkg::RED_RST;
      green_levels <= odpw_pkg::GREEN_RST;
      blue_levels  <= odpw_pkg::BLUE_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        odpw_pkg::REG_COLOR_MODE:   color_mode   <= pwdata[0];
        odpw_pkg::REG_FRAME_WIDTH:  frame_width  <= pwdata[11:0];
        odpw_pkg::REG_FRAME_HEIGHT: frame_height <= pwdata[11:0];
        odpw_pkg::REG_RED_LEVELS:   red_levels   <= pwdata[LB-1:0];
        odpw_pkg::REG_GREEN_LEVELS: green_levels <= pwdata[LB-1:0];
        odpw_pkg::REG_BLUE_LEVELS:  blue_levels  <= pwdata[LB-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      odpw_pkg::REG_COLOR_MODE:   prdata = {31'd0, color_mode};
      odpw_pkg::REG_FRAME_WIDTH:  prdata = {20'd0, frame_width};
      odpw_pkg::REG_FRAME_HEIGHT: prdata = {20'd0, frame_height};
      odpw_pkg::REG_RED_LEVELS:   prdata = {{(32-LB){1'b0}}, red_levels};
      odpw_pkg::REG_GREEN_LEVELS: prdata = {{(32-LB){1'b0}}, green_levels};
      odpw_pkg::REG_BLUE_LEVELS:  prdata = {{(32-LB){1'b0}}, blue_levels};
      default:                    prdata = 32'd0;
    endcase
  end

  // derived config values, stable while pixels are in flight if no register is written then
  logic [12:0]   width_eff;
  logic [GB-1:0] gain_r, gain_g, gain_b;
  logic [LB-1:0] ng_eff, nb_eff;
  logic [2*LB-1:0] gb_count;

  assign width_eff = ({1'b0, frame_width} > MaxW) ? MaxW : {1'b0, frame_width};
  assign gain_r    = odpw_pkg::chan_gain(red_levels);
  assign gain_g    = odpw_pkg::chan_gain(green_levels);
  assign gain_b    = odpw_pkg::chan_gain(blue_levels);
  assign ng_eff    = odpw_pkg::eff_levels(green_levels);
  assign nb_eff    = odpw_pkg::eff_levels(blue_levels);
  assign gb_count  = ng_eff * nb_eff;

  // stage 1: input register
  logic        v1;
  logic [11:0] x1, y1;
  logic [CB-1:0] r1, g1, b1;
  logic        se1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x1  <= pixel_x;
      y1  <= pixel_y;
      r1  <= red_in;
      g1  <= green_in;
      b1  <= blue_in;
      se1 <= span_end;
    end
  end

  // stage 2: clip and threshold lookup
  logic               vis1;
  logic               v2;
  odpw_pkg::pix_side_t s2;
  logic [7:0]         thr2;

  assign vis1 = !x1[11] && !y1[11] && ({1'b0, x1} < width_eff) && (y1 < frame_height);

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1 && vis1;
  end

  always_ff @(posedge clk) begin
    s2.x        <= x1[10:0];
    s2.y        <= y1[10:0];
    s2.span_end <= se1;
    s2.red      <= r1;
    s2.green    <= g1;
    s2.blue     <= b1;
    thr2        <= odpw_pkg::THRESHOLDS[{x1[3:0], y1[3:0]}];
  end

  // stage 3: scale each channel
  logic               v3;
  odpw_pkg::pix_side_t s3;
  logic [7:0]         thr3;
  logic [GB-1:0]      e_r3, e_g3, e_b3;
  logic [PB-1:0]      prod_r, prod_g, prod_b;

  assign prod_r = s2.red   * gain_r;
  assign prod_g = s2.green * gain_g;
  assign prod_b = s2.blue  * gain_b;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
  end

  always_ff @(posedge clk) begin
    s3   <= s2;
    thr3 <= thr2;
    e_r3 <= prod_r[PB-1:CB];
    e_g3 <= prod_g[PB-1:CB];
    e_b3 <= prod_b[PB-1:CB];
  end

  // stage 4: pick dithered levels
  logic               v4;
  odpw_pkg::pix_side_t s4;
  logic [LB-1:0]      q_r4, q_g4, q_b4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
  end

  always_ff @(posedge clk) begin
    s4   <= s3;
    q_r4 <= odpw_pkg::dither_level(e_r3, thr3);
    q_g4 <= odpw_pkg::dither_level(e_g3, thr3);
    q_b4 <= odpw_pkg::dither_level(e_b3, thr3);
  end

  // stage 5: weight levels into index terms
  logic               v5;
  odpw_pkg::pix_side_t s5;
  logic [3*LB-1:0]    term_r5;
  logic [2*LB-1:0]    term_g5;
  logic [LB-1:0]      q_b5;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
  end

  always_ff @(posedge clk) begin
    s5      <= s4;
    term_r5 <= q_r4 * gb_count;
    term_g5 <= q_g4 * nb_eff;
    q_b5    <= q_b4;
  end

  // stage 6: merge index or pack direct word, drive the result beat
  logic [odpw_pkg::INDEX_BITS-1:0] index5;
  logic [31:0]                     word5;

  assign index5 = odpw_pkg::INDEX_BITS'(term_r5)
                + odpw_pkg::INDEX_BITS'(term_g5)
                + odpw_pkg::INDEX_BITS'(q_b5);
  assign word5  = color_mode
                ? {odpw_pkg::ALPHA_BYTE, s5.blue, s5.green, s5.red}
                : {{(32-odpw_pkg::INDEX_BITS){1'b0}}, index5};

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v5;
  end

  always_ff @(posedge clk) begin
    out_x        <= s5.x;
    out_y        <= s5.y;
    out_span_end <= s5.span_end;
    pixel_word   <= word5;
  end

endmodule
